// ===== design/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared types, constants and series tables for the 4D rotation matrix block.
// ----------------------------------------------------------------------------
package fdr_pkg;

   localparam logic [30:0] TRIG_ONE    = 31'h4000_0000;
   localparam logic [30:0] TRIG_HALF   = 31'h2000_0000;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic [1:0] COL_FIRST = 2'd0;
   localparam logic [1:0] COL_LAST  = 2'd3;

   localparam int NUM_PLANES = 6;
   localparam int NUM_TERMS  = 7;

   // axis pairs (a,b) in order XY, YZ, ZX, XW, YW, ZW
   localparam int PLANE_A [6] = '{0, 1, 2, 0, 1, 2};
   localparam int PLANE_B [6] = '{1, 2, 0, 3, 3, 3};

   typedef struct packed {
      logic [1:0]  quad;
      logic [30:0] x;
      logic [31:0] x2;
      logic [30:0] h_sin;
      logic [30:0] h_cos;
   } fdr_trig_type;

   // series divisor: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
   function automatic logic [7:0] series_div(input logic [2:0] step, input logic odd);
      logic [7:0] d;
      d = 8'd1;
      unique case ({odd, step})
         4'b1_111: d = 8'd210;
         4'b1_110: d = 8'd156;
         4'b1_101: d = 8'd110;
         4'b1_100: d = 8'd72;
         4'b1_011: d = 8'd42;
         4'b1_010: d = 8'd20;
         4'b1_001: d = 8'd6;
         4'b0_111: d = 8'd182;
         4'b0_110: d = 8'd132;
         4'b0_101: d = 8'd90;
         4'b0_100: d = 8'd56;
         4'b0_011: d = 8'd30;
         4'b0_010: d = 8'd12;
         4'b0_001: d = 8'd2;
         default:  d = 8'd1;
      endcase
      return d;
   endfunction

   // ceil(2^32 / divisor), exact quotient for numerators below 2^24
   function automatic logic [31:0] series_rcp(input logic [2:0] step, input logic odd);
      logic [31:0] m;
      m = 32'hFFFF_FFFF;
      unique case ({odd, step})
         4'b1_111: m = 32'd20452226;
         4'b1_110: m = 32'd27531842;
         4'b1_101: m = 32'd39045158;
         4'b1_100: m = 32'd59652324;
         4'b1_011: m = 32'd102261127;
         4'b1_010: m = 32'd214748365;
         4'b1_001: m = 32'd715827883;
         4'b0_111: m = 32'd23598722;
         4'b0_110: m = 32'd32537632;
         4'b0_101: m = 32'd47721859;
         4'b0_100: m = 32'd76695845;
         4'b0_011: m = 32'd143165577;
         4'b0_010: m = 32'd357913942;
         4'b0_001: m = 32'd2147483648;
         default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// ===== design/fdr_term_cell.sv =====
// ----------------------------------------------------------------------------
// fdr_term_cell
// One Horner step of the sine and cosine series, four pipeline stages.
// ----------------------------------------------------------------------------
module fdr_term_cell #(
   parameter int STEP = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  vld_in,
   input  fdr_pkg::fdr_trig_type din,
   output logic                  vld_out,
   output fdr_pkg::fdr_trig_type dout
);

   localparam logic [7:0] DIV [2] = '{fdr_pkg::series_div(3'(STEP), 1'b1),
                                      fdr_pkg::series_div(3'(STEP), 1'b0)};
   localparam logic [31:0] RCP [2] = '{fdr_pkg::series_rcp(3'(STEP), 1'b1),
                                       fdr_pkg::series_rcp(3'(STEP), 1'b0)};

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   fdr_pkg::fdr_trig_type p1_ff, p2_ff, p3_ff, dout_ff, dout_in;

   logic [30:0] h_cur   [2];
   logic [62:0] prod1   [2];
   logic [31:0] t_in    [2];
   logic [31:0] t_ff    [2];
   logic [32:0] num     [2];
   logic [48:0] prod2   [2];
   logic [16:0] hi_in   [2];
   logic [16:0] hi_ff   [2];
   logic [15:0] nl_in   [2];
   logic [15:0] nl_ff   [2];
   logic [16:0] qh_in   [2];
   logic [16:0] qh2_ff  [2];
   logic [16:0] qh3_ff  [2];
   logic [16:0] rem     [2];
   logic [55:0] prod3   [2];
   logic [23:0] ql_in   [2];
   logic [23:0] ql_ff   [2];
   logic [33:0] quo     [2];
   logic [30:0] h_in    [2];

   // index 0: sine series, index 1: cosine series
   always_comb begin
      h_cur[0] = din.h_sin;
      h_cur[1] = din.h_cos;
      for (int g = 0; g < 2; g++) begin
         prod1[g] = 63'(din.x2) * 63'(h_cur[g]) + 63'(fdr_pkg::TRIG_HALF);
         t_in[g]  = prod1[g][61:30];
         num[g]   = 33'(t_ff[g]) + 33'(DIV[g] >> 1);
         hi_in[g] = num[g][32:16];
         nl_in[g] = num[g][15:0];
         prod2[g] = 49'(hi_in[g]) * 49'(RCP[g]);
         qh_in[g] = prod2[g][48:32];
         rem[g]   = hi_ff[g] - 17'(qh2_ff[g] * 17'(DIV[g]));
         prod3[g] = 56'({rem[g][7:0], nl_ff[g]}) * 56'(RCP[g]);
         ql_in[g] = prod3[g][55:32];
         quo[g]   = 34'({qh3_ff[g], 16'h0000}) + 34'(ql_ff[g]);
         h_in[g]  = (quo[g] >= 34'(fdr_pkg::TRIG_ONE)) ? '0 :
                    31'(34'(fdr_pkg::TRIG_ONE) - quo[g]);
      end
      dout_in       = p3_ff;
      dout_in.h_sin = h_in[0];
      dout_in.h_cos = h_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= vld_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= din;
         t_ff    <= t_in;
         p2_ff   <= p1_ff;
         hi_ff   <= hi_in;
         nl_ff   <= nl_in;
         qh2_ff  <= qh_in;
         p3_ff   <= p2_ff;
         qh3_ff  <= qh2_ff;
         ql_ff   <= ql_in;
         dout_ff <= dout_in;
      end
   end

   assign vld_out = v4_ff;
   assign dout    = dout_ff;

endmodule

// ===== design/fdr_sincos.sv =====
// ----------------------------------------------------------------------------
// fdr_sincos
// Sine and cosine of one binary angle in signed Q1.FRAC_BITS, pipelined.
// ----------------------------------------------------------------------------
module fdr_sincos #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        vld_in,
   input  logic [15:0]                 angle,
   output logic                        vld_out,
   output logic signed [FRAC_BITS+1:0] sin_out,
   output logic signed [FRAC_BITS+1:0] cos_out
);

   localparam int EXT = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
   localparam int EW  = FRAC_BITS + 2;
   localparam int FW  = FRAC_BITS + 1;
   localparam int SH  = 30 - FRAC_BITS;
   localparam logic [31:0] RND = (SH == 0) ? 32'd0 : (32'd1 << (SH - 1));

   logic [EXT-1:0]        ang_ext;
   logic [ANGLE_BITS-1:0] ang;
   logic [29:0]           ofs;
   logic [60:0]           xprod;
   logic [62:0]           sq;
   logic [61:0]           sprod;
   logic                  va_ff, vb_ff, vc_ff, vd_ff;
   logic [1:0]            quad_ff, qd_ff;
   logic [30:0]           x_ff;
   logic [30:0]           s_in, s_ff, c_ff;
   logic [31:0]           s_rnd, c_rnd;
   logic [FW-1:0]         s_frac, c_frac;
   logic signed [EW-1:0]  s_pos, c_pos, sin_in, cos_in, sin_ff, cos_ff;
   fdr_pkg::fdr_trig_type tb_in, tb_ff;
   fdr_pkg::fdr_trig_type tr [fdr_pkg::NUM_TERMS+1];
   logic                  vl [fdr_pkg::NUM_TERMS+1];

   always_comb begin
      ang_ext     = EXT'(angle);
      ang         = ang_ext[ANGLE_BITS-1:0];
      ofs         = 30'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
      xprod       = 61'(ofs) * 61'(fdr_pkg::HALF_PI_Q30) + 61'(fdr_pkg::TRIG_HALF);
      sq          = 63'(x_ff) * 63'(x_ff) + 63'(fdr_pkg::TRIG_HALF);
      tb_in.quad  = quad_ff;
      tb_in.x     = x_ff;
      tb_in.x2    = sq[61:30];
      tb_in.h_sin = fdr_pkg::TRIG_ONE;
      tb_in.h_cos = fdr_pkg::TRIG_ONE;
      sprod = 62'(tr[fdr_pkg::NUM_TERMS].x) * 62'(tr[fdr_pkg::NUM_TERMS].h_sin) +
              62'(fdr_pkg::TRIG_HALF);
      s_in  = (sprod[61:30] > 32'(fdr_pkg::TRIG_ONE)) ? fdr_pkg::TRIG_ONE :
              31'(sprod[61:30]);
      s_rnd  = 32'(s_ff) + RND;
      c_rnd  = 32'(c_ff) + RND;
      s_frac = FW'(s_rnd >> SH);
      c_frac = FW'(c_rnd >> SH);
      s_pos  = $signed({1'b0, s_frac});
      c_pos  = $signed({1'b0, c_frac});
      unique case (qd_ff)
         fdr_pkg::QUAD_0: begin
            sin_in = s_pos;
            cos_in = c_pos;
         end
         fdr_pkg::QUAD_1: begin
            sin_in = c_pos;
            cos_in = -s_pos;
         end
         fdr_pkg::QUAD_2: begin
            sin_in = -s_pos;
            cos_in = -c_pos;
         end
         fdr_pkg::QUAD_3: begin
            sin_in = -c_pos;
            cos_in = s_pos;
         end
      endcase
   end

   assign tr[0] = tb_ff;
   assign vl[0] = vb_ff;

   for (genvar k = 0; k < fdr_pkg::NUM_TERMS; k++) begin : g_term
      fdr_term_cell #(
         .STEP (fdr_pkg::NUM_TERMS - k)
      ) u_term (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (vl[k]),
         .din     (tr[k]),
         .vld_out (vl[k+1]),
         .dout    (tr[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= vld_in;
         vb_ff <= va_ff;
         vc_ff <= vl[fdr_pkg::NUM_TERMS];
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
         x_ff    <= xprod[60:30];
         tb_ff   <= tb_in;
         s_ff    <= s_in;
         c_ff    <= tr[fdr_pkg::NUM_TERMS].h_cos;
         qd_ff   <= tr[fdr_pkg::NUM_TERMS].quad;
         sin_ff  <= sin_in;
         cos_ff  <= cos_in;
      end
   end

   assign vld_out = vd_ff;
   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== design/fdr_plane_cell.sv =====
// ----------------------------------------------------------------------------
// fdr_plane_cell
// Applies one plane rotation to the running 4x4 matrix, one register stage.
// ----------------------------------------------------------------------------
module fdr_plane_cell #(
   parameter int FRAC_BITS = 16,
   parameter int PLANE     = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        vld_in,
   input  logic signed [FRAC_BITS+1:0] mat_in  [4][4],
   input  logic signed [FRAC_BITS+1:0] sn_in   [fdr_pkg::NUM_PLANES],
   input  logic signed [FRAC_BITS+1:0] cs_in   [fdr_pkg::NUM_PLANES],
   output logic                        vld_out,
   output logic signed [FRAC_BITS+1:0] mat_out [4][4],
   output logic signed [FRAC_BITS+1:0] sn_out  [fdr_pkg::NUM_PLANES],
   output logic signed [FRAC_BITS+1:0] cs_out  [fdr_pkg::NUM_PLANES]
);

   localparam int A  = fdr_pkg::PLANE_A[PLANE];
   localparam int B  = fdr_pkg::PLANE_B[PLANE];
   localparam int EW = FRAC_BITS + 2;
   localparam int PW = 2 * FRAC_BITS + 5;
   localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;

   logic                 vld_ff;
   logic signed [EW-1:0] mat_ff [4][4];
   logic signed [EW-1:0] nxt    [4][4];
   logic signed [EW-1:0] sn_ff  [fdr_pkg::NUM_PLANES];
   logic signed [EW-1:0] cs_ff  [fdr_pkg::NUM_PLANES];
   logic signed [EW-1:0] neg_s;

   // p*q + u*v, rounded half up to Q.FRAC_BITS and clamped to +-1.0
   function automatic logic signed [EW-1:0] rot(input logic signed [EW-1:0] p,
                                                input logic signed [EW-1:0] q,
                                                input logic signed [EW-1:0] u,
                                                input logic signed [EW-1:0] v);
      logic signed [PW-1:0] acc;
      logic signed [PW-1:0] shf;
      acc = p * q + u * v;
      shf = (acc + RND) >>> FRAC_BITS;
      priority if (shf > ONE) begin
         return EW'(ONE);
      end else if (shf < -ONE) begin
         return EW'(-ONE);
      end else begin
         return EW'(shf);
      end
   endfunction

   always_comb begin
      neg_s = -sn_in[PLANE];
      nxt   = mat_in;
      for (int r = 0; r < 4; r++) begin
         nxt[r][A] = rot(cs_in[PLANE], mat_in[r][A], neg_s, mat_in[r][B]);
         nxt[r][B] = rot(sn_in[PLANE], mat_in[r][A], cs_in[PLANE], mat_in[r][B]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff <= nxt;
         sn_ff  <= sn_in;
         cs_ff  <= cs_in;
      end
   end

   assign vld_out = vld_ff;
   assign mat_out = mat_ff;
   assign sn_out  = sn_ff;
   assign cs_out  = cs_ff;

endmodule

// ===== design/four_d_rotation_matrix.sv =====
// Latency: 39 register stages between the req transaction and column 0 offered on rsp.
// Each item leaves as four column transactions on the rsp port, which bound the item rate.
// The pipeline takes a new item every cycle until a finished matrix waits for the output
// register, then stalls as a whole until the last column of the previous item goes out.
// Reset clears all valid flags and the column sequencer; other registers are not reset.
// ----------------------------------------------------------------------------
// four_d_rotation_matrix
// 4x4 rotation matrix from six plane angles, streamed out one column a transaction.
// ----------------------------------------------------------------------------
module four_d_rotation_matrix #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // angle_xy, angle_yz, angle_zx, angle_xw, angle_yw, angle_zw (16 bits each)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_x, entry_y, entry_z, entry_w (18 bits each)
   output logic [71:0] rsp_tdata,
   // column_index
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int NP  = fdr_pkg::NUM_PLANES;
   localparam int EW  = FRAC_BITS + 2;
   localparam int SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int CW  = FRAC_BITS + SHL + 3;
   localparam logic signed [CW-1:0] ORND = (SHR == 0) ? CW'(0) : (CW'(1) <<< (SHR - 1));
   localparam logic signed [CW-1:0] OLIM = CW'(65536);
   localparam logic signed [EW-1:0] MONE = EW'(1) <<< FRAC_BITS;

   logic [NP-1:0]        sc_vld;
   logic signed [EW-1:0] sn   [NP+1][NP];
   logic signed [EW-1:0] cs   [NP+1][NP];
   logic signed [EW-1:0] mat  [NP+1][4][4];
   logic                 pvld [NP+1];
   logic                 pv, load, adv;
   logic                 busy_ff, busy_in;
   logic [1:0]           col_ff, col_in;
   logic [17:0]          out_ff [4][4];
   logic [17:0]          out_in [4][4];

   function automatic logic [17:0] cvt(input logic signed [EW-1:0] m);
      logic signed [CW-1:0] w;
      w = ((CW'(m) <<< SHL) + ORND) >>> SHR;
      priority if (w > OLIM) begin
         return 18'(OLIM);
      end else if (w < -OLIM) begin
         return 18'(-OLIM);
      end else begin
         return 18'(w);
      end
   endfunction

   for (genvar i = 0; i < NP; i++) begin : g_trig
      fdr_sincos #(
         .ANGLE_BITS (ANGLE_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_sincos (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .vld_in  (req_tvalid),
         .angle   (req_tdata[16*i +: 16]),
         .vld_out (sc_vld[i]),
         .sin_out (sn[0][i]),
         .cos_out (cs[0][i])
      );
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            mat[0][r][k] = (r == k) ? MONE : '0;
         end
      end
   end

   assign pvld[0] = &sc_vld;

   for (genvar p = 0; p < NP; p++) begin : g_plane
      fdr_plane_cell #(
         .FRAC_BITS (FRAC_BITS),
         .PLANE     (p)
      ) u_plane (
         .clock   (clock),
         .reset   (reset),
         .en      (adv),
         .vld_in  (pvld[p]),
         .mat_in  (mat[p]),
         .sn_in   (sn[p]),
         .cs_in   (cs[p]),
         .vld_out (pvld[p+1]),
         .mat_out (mat[p+1]),
         .sn_out  (sn[p+1]),
         .cs_out  (cs[p+1])
      );
   end

   assign pv   = pvld[NP];
   assign load = pv && (!busy_ff || (rsp_tready && col_ff == fdr_pkg::COL_LAST));
   assign adv  = !pv || load;

   always_comb begin
      busy_in = busy_ff;
      col_in  = col_ff;
      priority if (load) begin
         busy_in = 1'b1;
         col_in  = fdr_pkg::COL_FIRST;
      end else if (busy_ff && rsp_tready) begin
         busy_in = (col_ff != fdr_pkg::COL_LAST);
         col_in  = col_ff + 2'd1;
      end
      for (int k = 0; k < 4; k++) begin
         for (int r = 0; r < 4; r++) begin
            out_in[k][r] = cvt(mat[NP][r][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         col_ff  <= fdr_pkg::COL_FIRST;
      end else begin
         busy_ff <= busy_in;
         col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = col_ff;
   assign rsp_tlast  = (col_ff == fdr_pkg::COL_LAST);
   assign rsp_tdata  = {out_ff[col_ff][3], out_ff[col_ff][2],
                        out_ff[col_ff][1], out_ff[col_ff][0]};

   a_load_starts_col0: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && col_ff == fdr_pkg::COL_FIRST)
      else $error("column sequencer did not restart on load");

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rsp_tready && col_ff != fdr_pkg::COL_LAST |=>
      busy_ff && col_ff == 2'($past(col_ff) + 2'd1))
      else $error("column index skipped or repeated");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      pv && !adv |=> pv)
      else $error("finished matrix lost during stall");

   a_no_load_midframe: assert property (@(posedge clock) disable iff (reset)
      busy_ff && col_ff != fdr_pkg::COL_LAST |-> !load)
      else $error("matrix reloaded before last column went out");

endmodule
